// ----- rtl/mgbo_pkg.sv -----
`timescale 1ns / 1ps
package mgbo_pkg;

    localparam int GRID_COLUMNS = 20;
    localparam int GRID_ROWS    = 15;
    localparam int MASK_BYTES   = 38;
    localparam int COORD_BITS   = 12;

    localparam int CELL_BITS  = $clog2(GRID_COLUMNS * GRID_ROWS + 1);
    localparam int MADDR_BITS = (MASK_BYTES > 1) ? $clog2(MASK_BYTES) : 1;
    localparam int BYTE_BITS  = (CELL_BITS > 3) ? CELL_BITS - 3 : 1;
    localparam int CW_BITS    = 8;
    localparam int CH_BITS    = 9;
    localparam int REM_BITS   = CH_BITS;
    localparam int CFG_BITS   = 9;
    localparam int CIDX_BITS  = 3;

    localparam logic [CIDX_BITS-1:0] REG_CELL_W  = 3'd0;
    localparam logic [CIDX_BITS-1:0] REG_CELL_H  = 3'd1;
    localparam logic [CIDX_BITS-1:0] REG_THICK   = 3'd2;
    localparam logic [CIDX_BITS-1:0] REG_INVERT  = 3'd3;
    localparam logic [CIDX_BITS-1:0] REG_BOX_Y   = 3'd4;
    localparam logic [CIDX_BITS-1:0] REG_BOX_CB  = 3'd5;
    localparam logic [CIDX_BITS-1:0] REG_BOX_CR  = 3'd6;
    localparam logic [CIDX_BITS-1:0] REG_ALPHA   = 3'd7;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    typedef struct packed {
        logic                  cmd;
        logic [5:0]            idx;
        logic [7:0]            mbyte;
        logic [7:0]            luma;
        logic [7:0]            cb;
        logic [7:0]            cr;
        logic [COORD_BITS-1:0] xn;
        logic [COORD_BITS-1:0] yn;
        logic [COORD_BITS-1:0] qx;
        logic [COORD_BITS-1:0] qy;
        logic [REM_BITS-1:0]   rx;
        logic [REM_BITS-1:0]   ry;
    } t_item;

    // one restoring-division step on both coordinate lanes
    function automatic t_item div_step(t_item s, logic [CH_BITS-1:0] dvx,
                                       logic [CH_BITS-1:0] dvy);
        t_item               r;
        logic [REM_BITS:0]   tx;
        logic [REM_BITS:0]   ty;
        logic                bx;
        logic                by;
        r  = s;
        tx = {s.rx, s.xn[COORD_BITS-1]};
        ty = {s.ry, s.yn[COORD_BITS-1]};
        bx = (tx >= {1'b0, dvx});
        by = (ty >= {1'b0, dvy});
        r.rx = bx ? REM_BITS'(tx - {1'b0, dvx}) : tx[REM_BITS-1:0];
        r.ry = by ? REM_BITS'(ty - {1'b0, dvy}) : ty[REM_BITS-1:0];
        r.xn = {s.xn[COORD_BITS-2:0], 1'b0};
        r.yn = {s.yn[COORD_BITS-2:0], 1'b0};
        r.qx = {s.qx[COORD_BITS-2:0], bx};
        r.qy = {s.qy[COORD_BITS-2:0], by};
        return r;
    endfunction

    // exact floor(v / 255) for v up to 255*255
    function automatic logic [7:0] div255(logic [15:0] v);
        logic [16:0] s;
        s = {1'b0, v} + 17'(v[15:8]) + 17'd1;
        return s[15:8];
    endfunction

endpackage

// ----- rtl/mgbo_ram.sv -----
`timescale 1ns / 1ps
module mgbo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 38
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/mgbo_div.sv -----
`timescale 1ns / 1ps
module mgbo_div
    import mgbo_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  t_item              i_item,
    input  logic [CH_BITS-1:0] i_dvx,
    input  logic [CH_BITS-1:0] i_dvy,
    output logic               o_vld,
    output t_item              o_item
);

    logic [COORD_BITS-1:0] r_vld;
    t_item                 r_st [COORD_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[COORD_BITS-2:0], i_vld};
        end
    end

    // one quotient bit per stage, MSB first
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= div_step(i_item, i_dvx, i_dvy);
            for (int k = 1; k < COORD_BITS; k++) begin
                r_st[k] <= div_step(r_st[k-1], i_dvx, i_dvy);
            end
        end
    end

    assign o_vld  = r_vld[COORD_BITS-1];
    assign o_item = r_st[COORD_BITS-1];

endmodule

// ----- rtl/motion_grid_box_overlay_top.sv -----
`timescale 1ns / 1ps
// Motion grid box overlay.
// Input channel (i_valid / o_stall) carries commands: a mask load
// (i_command 0) stores one byte of the cell bitmap, a pixel (i_command 1)
// returns one result on the output channel (o_valid / i_stall). Loads give
// no result. Configuration is written through i_cfg_we / i_cfg_idx /
// i_cfg_data; the user must write it only while the block is idle, as the block does not enforce this.
// Throughput is one item per clock while o_stall is low. From input transfer
// to output valid an item passes the pipelined restoring divider that
// finds the cell column and row (one quotient bit per stage, the first
// stage takes the transfer), then the mask memory read, and then the
// output register, which also takes the blend.
// The cell bitmap is a 38-byte single-port-read memory, read-modify order
// is kept by doing loads and lookups at the same pipeline stage.
// Reset clears the pipeline, the output register and all cell marks, and
// loads the register defaults; the block takes items right after reset.
// When the receiver stalls, a skid register takes the next result and
// o_stall rises (registered) until the skid drains.
module motion_grid_box_overlay_top
    import mgbo_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_command,
    input  logic [5:0]           i_mask_index,
    input  logic [7:0]           i_mask_byte,
    input  logic [COORD_BITS-1:0] i_pixel_x,
    input  logic [COORD_BITS-1:0] i_pixel_y,
    input  logic [7:0]           i_luma_in,
    input  logic [7:0]           i_cb_in,
    input  logic [7:0]           i_cr_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_luma_out,
    output logic [7:0]           o_cb_out,
    output logic [7:0]           o_cr_out,
    output logic                 o_on_outline,
    input  logic                 i_cfg_we,
    input  logic [CIDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]  i_cfg_data
);

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] cb;
        logic [7:0] cr;
        logic       hit;
    } t_res;

    // configuration
    logic [CW_BITS-1:0] r_cell_w;
    logic [CH_BITS-1:0] r_cell_h;
    logic [7:0]         r_thick;
    logic               r_invert;
    logic [7:0]         r_box_y;
    logic [7:0]         r_box_cb;
    logic [7:0]         r_box_cr;
    logic [7:0]         r_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_w <= 8'd96;
            r_cell_h <= 9'd72;
            r_thick  <= 8'd3;
            r_invert <= 1'b0;
            r_box_y  <= 8'd16;
            r_box_cb <= 8'd128;
            r_box_cr <= 8'd128;
            r_alpha  <= 8'd255;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CELL_W: r_cell_w <= i_cfg_data[CW_BITS-1:0];
                REG_CELL_H: r_cell_h <= i_cfg_data[CH_BITS-1:0];
                REG_THICK:  r_thick  <= i_cfg_data[7:0];
                REG_INVERT: r_invert <= i_cfg_data[0];
                REG_BOX_Y:  r_box_y  <= i_cfg_data[7:0];
                REG_BOX_CB: r_box_cb <= i_cfg_data[7:0];
                REG_BOX_CR: r_box_cr <= i_cfg_data[7:0];
                REG_ALPHA:  r_alpha  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // pipeline control: everything advances unless the skid is full
    logic r_s_v;
    logic w_en;
    assign w_en    = !r_s_v;
    assign o_stall = r_s_v;

    t_item w_in;
    always_comb begin
        w_in       = '0;
        w_in.cmd   = i_command;
        w_in.idx   = i_mask_index;
        w_in.mbyte = i_mask_byte;
        w_in.luma  = i_luma_in;
        w_in.cb    = i_cb_in;
        w_in.cr    = i_cr_in;
        w_in.xn    = i_pixel_x;
        w_in.yn    = i_pixel_y;
    end

    logic  w_d_vld;
    t_item w_d;

    mgbo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_valid && w_en),
        .i_item  (w_in),
        .i_dvx   ({1'b0, r_cell_w}),
        .i_dvy   (r_cell_h),
        .o_vld   (w_d_vld),
        .o_item  (w_d)
    );

    // lookup stage: cell number, border test, mask access
    logic                  w_inside;
    logic [CELL_BITS-1:0]  w_cell;
    logic [BYTE_BITS-1:0]  w_byte;
    logic                  w_byte_ok;
    logic                  w_edge;
    logic [CW_BITS-1:0]    w_dx;
    logic [CH_BITS-1:0]    w_dy;
    logic [CW_BITS-1:0]    w_rx_far;
    logic [CH_BITS-1:0]    w_ry_far;
    logic                  w_we;
    logic                  w_re;

    always_comb begin
        w_inside  = (r_cell_w != '0) && (r_cell_h != '0) &&
                    (w_d.qx < COORD_BITS'(GRID_COLUMNS)) &&
                    (w_d.qy < COORD_BITS'(GRID_ROWS));
        w_cell    = CELL_BITS'(w_d.qy * GRID_COLUMNS + w_d.qx);
        w_byte    = w_cell[CELL_BITS-1:3];
        w_byte_ok = ({1'b0, w_byte} < (BYTE_BITS+1)'(MASK_BYTES));
        w_dx      = w_d.rx[CW_BITS-1:0];
        w_dy      = w_d.ry;
        w_rx_far  = r_cell_w - 8'd1 - w_dx;
        w_ry_far  = r_cell_h - 9'd1 - w_dy;
        w_edge    = (w_dx < r_thick) || (w_dy < {1'b0, r_thick}) ||
                    (w_rx_far < r_thick) || (w_ry_far < {1'b0, r_thick});
        w_we      = w_en && w_d_vld && (w_d.cmd == CMD_LOAD) &&
                    ({1'b0, w_d.idx} < 7'(MASK_BYTES));
        w_re      = w_en && w_d_vld && (w_d.cmd == CMD_PIXEL);
    end

    logic [7:0]            w_rdata;
    logic [MASK_BYTES-1:0] r_mvld;

    mgbo_ram #(
        .WIDTH (8),
        .DEPTH (MASK_BYTES)
    ) u_mask (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_d.idx[MADDR_BITS-1:0]),
        .i_wdata (w_d.mbyte),
        .i_re    (w_re),
        .i_raddr (w_byte[MADDR_BITS-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvld <= '0;
        end else if (w_we) begin
            r_mvld[w_d.idx[MADDR_BITS-1:0]] <= 1'b1;
        end
    end

    logic        r_a_vld;
    logic        r_a_cmd;
    logic        r_a_cand;
    logic        r_a_mvld;
    logic [2:0]  r_a_bit;
    logic [7:0]  r_a_y;
    logic [7:0]  r_a_cb;
    logic [7:0]  r_a_cr;
    logic [15:0] r_a_py, r_a_pcb, r_a_pcr;
    logic [15:0] r_a_cy, r_a_ccb, r_a_ccr;
    logic [7:0]  w_ialpha;

    assign w_ialpha = 8'd255 - r_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= w_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_cmd  <= w_d.cmd;
            r_a_cand <= w_inside && w_byte_ok && w_edge;
            r_a_mvld <= r_mvld[w_byte[MADDR_BITS-1:0]] && w_byte_ok;
            r_a_bit  <= w_cell[2:0];
            r_a_y    <= w_d.luma;
            r_a_cb   <= w_d.cb;
            r_a_cr   <= w_d.cr;
            r_a_py   <= 16'(w_ialpha) * 16'(w_d.luma);
            r_a_pcb  <= 16'(w_ialpha) * 16'(w_d.cb);
            r_a_pcr  <= 16'(w_ialpha) * 16'(w_d.cr);
            r_a_cy   <= 16'(r_alpha) * 16'(r_box_y);
            r_a_ccb  <= 16'(r_alpha) * 16'(r_box_cb);
            r_a_ccr  <= 16'(r_alpha) * 16'(r_box_cr);
        end
    end

    // blend stage
    logic w_res_v;
    t_res w_res;
    logic w_hit;

    always_comb begin
        w_hit   = r_a_cand && r_a_mvld && w_rdata[r_a_bit];
        w_res_v = w_en && r_a_vld && (r_a_cmd == CMD_PIXEL);
        w_res.hit  = w_hit;
        w_res.luma = r_a_y;
        w_res.cb   = r_a_cb;
        w_res.cr   = r_a_cr;
        if (w_hit) begin
            if (r_invert) begin
                w_res.luma = 8'd255 - r_a_y;
            end else begin
                w_res.luma = div255(r_a_py + r_a_cy);
                w_res.cb   = div255(r_a_pcb + r_a_ccb);
                w_res.cr   = div255(r_a_pcr + r_a_ccr);
            end
        end
    end

    // output register with skid
    logic r_o_v;
    t_res r_o;
    t_res r_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
            r_s_v <= 1'b0;
        end else if (r_s_v) begin
            if (!i_stall) begin
                r_s_v <= 1'b0;
                r_o_v <= 1'b1;
            end
        end else if (w_res_v) begin
            if (!r_o_v || !i_stall) begin
                r_o_v <= 1'b1;
            end else begin
                r_s_v <= 1'b1;
            end
        end else if (!i_stall) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s_v) begin
            if (!i_stall) begin
                r_o <= r_s;
            end
        end else if (w_res_v) begin
            if (!r_o_v || !i_stall) begin
                r_o <= w_res;
            end else begin
                r_s <= w_res;
            end
        end
    end

    assign o_valid      = r_o_v;
    assign o_luma_out   = r_o.luma;
    assign o_cb_out     = r_o.cb;
    assign o_cr_out     = r_o.cr;
    assign o_on_outline = r_o.hit;

endmodule

// ----- rtl/mgbo_chk.sv -----
`timescale 1ns / 1ps
module mgbo_chk (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [7:0]            o_luma_out,
    input logic [7:0]            o_cb_out,
    input logic [7:0]            o_cr_out,
    input logic                  o_on_outline
);

    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("outputs not cleared by reset");

    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output register");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stall rose without an output stall");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_luma_out) &&
                                  $stable(o_cb_out) && $stable(o_cr_out) &&
                                  $stable(o_on_outline)))
        else $error("stalled result changed");

endmodule

bind motion_grid_box_overlay_top mgbo_chk u_mgbo_chk (.*);

// ----- tb/motion_grid_box_overlay_top_tb.sv -----
`timescale 1ns / 1ps
module motion_grid_box_overlay_top_tb;
    import mgbo_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 40;

    typedef struct {
        logic [7:0] luma;
        logic [7:0] cb;
        logic [7:0] cr;
        logic       outline;
    } t_pix;

    typedef struct {
        logic                  cmd;
        logic [5:0]            idx;
        logic [7:0]            mbyte;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [7:0]            luma;
        logic [7:0]            cb;
        logic [7:0]            cr;
        bit                    typed;
        t_pix                  want;
    } t_stim;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_command = CMD_LOAD;
    logic [5:0]            i_mask_index = '0;
    logic [7:0]            i_mask_byte = '0;
    logic [COORD_BITS-1:0] i_pixel_x = '0;
    logic [COORD_BITS-1:0] i_pixel_y = '0;
    logic [7:0]            i_luma_in = '0;
    logic [7:0]            i_cb_in = '0;
    logic [7:0]            i_cr_in = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [7:0]            o_luma_out;
    logic [7:0]            o_cb_out;
    logic [7:0]            o_cr_out;
    logic                  o_on_outline;
    logic                  i_cfg_we = 1'b0;
    logic [CIDX_BITS-1:0]  i_cfg_idx = REG_CELL_W;
    logic [CFG_BITS-1:0]   i_cfg_data = '0;

    motion_grid_box_overlay_top u_top (.*);

    always #10 i_clk = ~i_clk;

    // local copy of block state
    logic [7:0] mark_bytes [MASK_BYTES];
    int unsigned cell_w, cell_h, thick, invert, box_y, box_cb, box_cr, alpha;

    t_pix pending_pix [$];
    int   err_count = 0;
    int   sent_count = 0;
    int   pix_count = 0;
    int   load_count = 0;
    int   outline_count = 0;
    int   checked_count = 0;
    int   cycle_count = 0;
    bit   quiet = 1'b0;
    bit   hold_done = 1'b0;
    int   hold_left = 0;

    function automatic logic [7:0] blend(int unsigned p, int unsigned c, int unsigned a);
        return 8'(((255 - a) * p + a * c) / 255);
    endfunction

    function automatic t_pix overlay_pixel(t_stim s);
        t_pix        r;
        int unsigned col, row, n, dx, dy;
        bit          hit;
        hit = 1'b0;
        r.luma = s.luma;
        r.cb = s.cb;
        r.cr = s.cr;
        if (cell_w != 0 && cell_h != 0) begin
            col = s.x / cell_w;
            row = s.y / cell_h;
            if (col < GRID_COLUMNS && row < GRID_ROWS) begin
                n = row * GRID_COLUMNS + col;
                if ((n >> 3) < MASK_BYTES && mark_bytes[n >> 3][n & 7]) begin
                    dx = s.x - col * cell_w;
                    dy = s.y - row * cell_h;
                    hit = dx < thick || dy < thick ||
                          (cell_w - 1 - dx) < thick || (cell_h - 1 - dy) < thick;
                end
            end
        end
        if (hit) begin
            if (invert != 0) begin
                r.luma = 8'(255 - s.luma);
            end else begin
                r.luma = blend(s.luma, box_y, alpha);
                r.cb = blend(s.cb, box_cb, alpha);
                r.cr = blend(s.cr, box_cr, alpha);
            end
        end
        r.outline = hit;
        return r;
    endfunction

    // advance local state on a transfer and queue the pixel result
    function automatic void accept(t_stim s);
        t_pix p;
        sent_count++;
        if (s.cmd == CMD_LOAD) begin
            load_count++;
            if (s.idx < MASK_BYTES) mark_bytes[s.idx] = s.mbyte;
        end else begin
            pix_count++;
            p = overlay_pixel(s);
            if (p.outline) outline_count++;
            pending_pix.push_back(s.typed ? s.want : p);
        end
    endfunction

    task automatic drive(t_stim s);
        if (!quiet) begin
            while ($urandom_range(0, 99) < 10) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_command <= s.cmd;
        i_mask_index <= s.idx;
        i_mask_byte <= s.mbyte;
        i_pixel_x <= s.x;
        i_pixel_y <= s.y;
        i_luma_in <= s.luma;
        i_cb_in <= s.cb;
        i_cr_in <= s.cr;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        accept(s);
    endtask

    // write all registers; block must be idle
    task automatic configure(int unsigned w, int unsigned h, int unsigned t, int unsigned inv,
                             int unsigned cy, int unsigned ccb, int unsigned ccr,
                             int unsigned a);
        logic [CFG_BITS-1:0] vals [8];
        logic [CIDX_BITS-1:0] regs [8];
        vals = '{CFG_BITS'(w), CFG_BITS'(h), CFG_BITS'(t), CFG_BITS'(inv),
                 CFG_BITS'(cy), CFG_BITS'(ccb), CFG_BITS'(ccr), CFG_BITS'(a)};
        regs = '{REG_CELL_W, REG_CELL_H, REG_THICK, REG_INVERT,
                 REG_BOX_Y, REG_BOX_CB, REG_BOX_CR, REG_ALPHA};
        i_valid <= 1'b0;
        while (pending_pix.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        for (int k = 0; k < 8; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= regs[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cell_w = w & 8'hff;
        cell_h = h & 9'h1ff;
        thick = t & 8'hff;
        invert = inv & 1;
        box_y = cy & 8'hff;
        box_cb = ccb & 8'hff;
        box_cr = ccr & 8'hff;
        alpha = a & 8'hff;
    endtask

    function automatic t_stim load_row(int unsigned idx, int unsigned b);
        t_stim s;
        s = '{default: '0};
        s.cmd = CMD_LOAD;
        s.idx = 6'(idx);
        s.mbyte = 8'(b);
        return s;
    endfunction

    function automatic t_stim pix_row(int unsigned x, int unsigned y, int unsigned l,
                                      int unsigned cb, int unsigned cr);
        t_stim s;
        s = '{default: '0};
        s.cmd = CMD_PIXEL;
        s.x = COORD_BITS'(x);
        s.y = COORD_BITS'(y);
        s.luma = 8'(l);
        s.cb = 8'(cb);
        s.cr = 8'(cr);
        return s;
    endfunction

    function automatic t_stim typed_row(t_stim s, int unsigned l, int unsigned cb,
                                        int unsigned cr, bit ol);
        s.typed = 1'b1;
        s.want = '{8'(l), 8'(cb), 8'(cr), ol};
        return s;
    endfunction

    function automatic t_stim random_item();
        t_stim       s;
        int unsigned xspan, yspan;
        if ($urandom_range(0, 99) < 15) begin
            if ($urandom_range(0, 9) == 0) return load_row($urandom_range(0, 63), $urandom);
            return load_row($urandom_range(0, MASK_BYTES - 1), $urandom);
        end
        xspan = (GRID_COLUMNS + 1) * (cell_w == 0 ? 8 : cell_w);
        yspan = (GRID_ROWS + 1) * (cell_h == 0 ? 8 : cell_h);
        if (xspan > 4095) xspan = 4095;
        if (yspan > 4095) yspan = 4095;
        s = pix_row($urandom_range(0, xspan), $urandom_range(0, yspan),
                    $urandom, $urandom, $urandom);
        if ($urandom_range(0, 9) == 0) begin
            s.x = COORD_BITS'($urandom);
            s.y = COORD_BITS'($urandom);
        end
        return s;
    endfunction

    t_stim directed [$];

    initial begin
        for (int k = 0; k < MASK_BYTES; k++) mark_bytes[k] = '0;
        cell_w = 96; cell_h = 72; thick = 3; invert = 0;
        box_y = 16; box_cb = 128; box_cr = 128; alpha = 255;

        // reset defaults, empty mask, opaque box, marks at both mask ends
        directed.push_back(typed_row(pix_row(0, 0, 200, 10, 250), 200, 10, 250, 0));
        directed.push_back(load_row(0, 8'hff));
        directed.push_back(typed_row(pix_row(0, 0, 200, 10, 250), 16, 128, 128, 1));
        directed.push_back(typed_row(pix_row(95, 71, 0, 255, 0), 16, 128, 128, 1));
        directed.push_back(typed_row(pix_row(50, 50, 77, 88, 99), 77, 88, 99, 0));
        directed.push_back(typed_row(pix_row(4095, 4095, 1, 2, 3), 1, 2, 3, 0));
        directed.push_back(load_row(63, 8'hff));
        directed.push_back(load_row(MASK_BYTES, 8'hff));
        directed.push_back(load_row(MASK_BYTES - 1, 8'hff));
        directed.push_back(typed_row(pix_row(1824, 1008, 255, 255, 255), 16, 128, 128, 1));
        directed.push_back(typed_row(pix_row(1919, 1040, 0, 0, 0), 16, 128, 128, 1));
        directed.push_back(typed_row(pix_row(1920, 1040, 9, 9, 9), 9, 9, 9, 0));
        directed.push_back(typed_row(pix_row(1850, 1079, 5, 6, 7), 16, 128, 128, 1));
        directed.push_back(typed_row(pix_row(1850, 1080, 5, 6, 7), 5, 6, 7, 0));
        directed.push_back(pix_row(97, 0, 128, 64, 32));
        directed.push_back(load_row(5, 8'h5a));
        directed.push_back(pix_row(3 * 96 + 1, 2 * 72, 33, 44, 55));
        directed.push_back(pix_row(4095, 0, 255, 0, 255));
        directed.push_back(pix_row(0, 4095, 0, 255, 0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) drive(directed[k]);

        // invert mode, zero thickness, zero cell size and transparent box checks on the loaded marks
        configure(96, 72, 3, 1, 16, 128, 128, 255);
        drive(typed_row(pix_row(0, 0, 200, 10, 250), 55, 10, 250, 1));
        drive(typed_row(pix_row(50, 50, 200, 10, 250), 200, 10, 250, 0));
        configure(96, 72, 0, 0, 16, 128, 128, 255);
        drive(typed_row(pix_row(0, 0, 200, 10, 250), 200, 10, 250, 0));
        configure(0, 72, 3, 0, 16, 128, 128, 255);
        drive(typed_row(pix_row(0, 0, 200, 10, 250), 200, 10, 250, 0));
        configure(96, 0, 3, 0, 16, 128, 128, 255);
        drive(typed_row(pix_row(0, 0, 200, 10, 250), 200, 10, 250, 0));
        configure(96, 72, 3, 0, 16, 128, 128, 0);
        drive(typed_row(pix_row(0, 0, 200, 10, 250), 200, 10, 250, 1));

        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: configure(1, 1, 1, 0, $urandom, $urandom, $urandom, $urandom);
                1: configure(204, 273, 255, 1, $urandom, $urandom, $urandom, $urandom);
                2: configure(255, 511, 0, 0, $urandom, $urandom, $urandom, 255);
                3: configure(0, 0, 5, 0, $urandom, $urandom, $urandom, 128);
                4: configure(7, 5, 2, 0, 255, 0, 255, 0);
                5: configure(13, 9, 3, 1, 0, 255, 0, 255);
                6: configure(96, 72, 3, 0, 16, 128, 128, 255);
                default: configure($urandom_range(1, 40), $urandom_range(1, 40),
                                   $urandom_range(0, 20), $urandom_range(0, 1),
                                   $urandom, $urandom, $urandom, $urandom);
            endcase
            for (int k = 0; k < 190; k++) begin
                quiet = (ph == 6);
                drive(random_item());
            end
        end
        quiet = 1'b0;
        i_valid <= 1'b0;
        while (pending_pix.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("transfers %0d: %0d mask loads, %0d pixels (%0d on outline), %0d checked",
                 sent_count, load_count, pix_count, outline_count, checked_count);
        $display("covered register extremes, zero cell size, zero thickness, both modes");
        if (err_count == 0) begin
            $display("motion_grid_box_overlay_top_tb: done, clean");
        end else begin
            $display("mismatches: %0d", err_count);
            $display("motion_grid_box_overlay_top_tb: done, errors");
        end
        $finish;
    end

    // output side: check each transfer, random stall plus one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            checked_count++;
            if (pending_pix.size() == 0) begin
                err_count++;
                if (err_count <= 10) $display("unexpected result luma %0d", o_luma_out);
            end else begin
                t_pix w;
                w = pending_pix.pop_front();
                if (w.luma !== o_luma_out || w.cb !== o_cb_out || w.cr !== o_cr_out ||
                    w.outline !== o_on_outline) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 w.luma, w.cb, w.cr, w.outline,
                                 o_luma_out, o_cb_out, o_cr_out, o_on_outline);
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!hold_done && sent_count >= 400) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !quiet && ($urandom_range(0, 99) < 10);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("motion_grid_box_overlay_top_tb: done, errors");
            $finish;
        end
    end

endmodule

// ----- files.f -----
rtl/mgbo_pkg.sv
rtl/mgbo_ram.sv
rtl/mgbo_div.sv
rtl/motion_grid_box_overlay_top.sv
rtl/mgbo_chk.sv
tb/motion_grid_box_overlay_top_tb.sv
